/* src/tepac_pkg.sv */
// ----------------------------------------------------------------------------
// tepac_pkg
// Shared types and constants for the touch event pairing and affine
// calibration block.
// ----------------------------------------------------------------------------
package tepac_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int FIELD_W     = 16;
	localparam int COEF_W      = 32;
	localparam int POS_W       = 16;
	localparam int REG_IDX_W   = 3;
	// coefficient times zero-extended sample, exact
	localparam int PROD_W      = COEF_W + SAMPLE_BITS + 1;
	// two products plus offset, exact
	localparam int ACC_W       = PROD_W + 2;

	localparam logic [FIELD_W-1:0] EV_ABS = FIELD_W'(3);
	localparam logic [FIELD_W-1:0] AXIS_X = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] AXIS_Y = FIELD_W'(1);

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_IDLE  = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_XX  = 3'd0,
		REG_GAIN_XY  = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_GAIN_YX  = 3'd3,
		REG_GAIN_YY  = 3'd4,
		REG_OFFSET_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] ev_type;
		logic [FIELD_W-1:0] ev_code;
		logic [FIELD_W-1:0] ev_value;
	} in_beat_t;

	typedef struct packed {
		logic                    touched;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} out_beat_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] gain_xx;
		logic signed [COEF_W-1:0] gain_xy;
		logic signed [COEF_W-1:0] offset_x;
		logic signed [COEF_W-1:0] gain_yx;
		logic signed [COEF_W-1:0] gain_yy;
		logic signed [COEF_W-1:0] offset_y;
	} coef_set_t;

	// paired raw samples, or an idle marker
	typedef struct packed {
		logic                   touched;
		logic [SAMPLE_BITS-1:0] rx;
		logic [SAMPLE_BITS-1:0] ry;
	} pair_beat_t;

	typedef struct packed {
		logic                     touched;
		logic signed [PROD_W-1:0] px_a;
		logic signed [PROD_W-1:0] px_b;
		logic signed [PROD_W-1:0] py_a;
		logic signed [PROD_W-1:0] py_b;
	} prod_beat_t;

endpackage

/* src/tepac_cfg.sv */
// ----------------------------------------------------------------------------
// tepac_cfg
// Calibration coefficient registers with a plain write port.
// ----------------------------------------------------------------------------
module tepac_cfg
	import tepac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [COEF_W-1:0]    cfg_wdata,
	output coef_set_t            coef
);

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.gain_xx  <= COEF_W'(1 << FRAC_BITS);
			coef_q.gain_xy  <= '0;
			coef_q.offset_x <= '0;
			coef_q.gain_yx  <= '0;
			coef_q.gain_yy  <= COEF_W'(1 << FRAC_BITS);
			coef_q.offset_y <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_GAIN_XX:  coef_q.gain_xx  <= cfg_wdata;
				REG_GAIN_XY:  coef_q.gain_xy  <= cfg_wdata;
				REG_OFFSET_X: coef_q.offset_x <= cfg_wdata;
				REG_GAIN_YX:  coef_q.gain_yx  <= cfg_wdata;
				REG_GAIN_YY:  coef_q.gain_yy  <= cfg_wdata;
				REG_OFFSET_Y: coef_q.offset_y <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

/* src/tepac_pair.sv */
// ----------------------------------------------------------------------------
// tepac_pair
// Input stage: collects the first X and Y axis samples into a pair and
// registers a beat for every pair completed and every idle tick.
// ----------------------------------------------------------------------------
module tepac_pair
	import tepac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_beat_t   in_beat,
	input  logic       dn_ready,
	output logic       pair_valid,
	output pair_beat_t pair_beat
);

	logic [SAMPLE_BITS-1:0] raw_x_q;
	logic [SAMPLE_BITS-1:0] raw_y_q;
	logic                   have_x_q;
	logic                   have_y_q;
	logic                   valid_s1;
	pair_beat_t             beat_s1;

	logic                   ready;
	logic                   accept;
	logic                   is_idle;
	logic                   take_x;
	logic                   take_y;
	logic                   hx;
	logic                   hy;
	logic                   pair_done;
	logic                   emit;
	logic [SAMPLE_BITS-1:0] sample;

	assign ready    = !valid_s1 || dn_ready;
	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	assign sample  = in_beat.ev_value[SAMPLE_BITS-1:0];
	assign is_idle = (in_beat.op == OP_IDLE);
	assign take_x  = !is_idle && (in_beat.ev_type == EV_ABS) &&
		(in_beat.ev_code == AXIS_X) && !have_x_q;
	assign take_y  = !is_idle && (in_beat.ev_type == EV_ABS) &&
		(in_beat.ev_code == AXIS_Y) && !have_y_q;
	assign hx        = have_x_q || take_x;
	assign hy        = have_y_q || take_y;
	assign pair_done = !is_idle && hx && hy;
	assign emit      = is_idle || pair_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_x_q <= 1'b0;
			have_y_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && !is_idle) begin
				have_x_q <= hx && !pair_done;
				have_y_q <= hy && !pair_done;
			end
			if (ready) begin
				valid_s1 <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take_x) begin
			raw_x_q <= sample;
		end
		if (accept && take_y) begin
			raw_y_q <= sample;
		end
		if (accept && emit) begin
			beat_s1.touched <= !is_idle;
			beat_s1.rx      <= take_x ? sample : raw_x_q;
			beat_s1.ry      <= take_y ? sample : raw_y_q;
		end
	end

	assign pair_valid = valid_s1;
	assign pair_beat  = beat_s1;

endmodule

/* src/tepac_mul.sv */
// ----------------------------------------------------------------------------
// tepac_mul
// Product stage: the four coefficient by sample products.
// ----------------------------------------------------------------------------
module tepac_mul
	import tepac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  coef_set_t  coef,
	input  logic       pair_valid,
	input  pair_beat_t pair_beat,
	output logic       up_ready,
	input  logic       dn_ready,
	output logic       prod_valid,
	output prod_beat_t prod_beat
);

	logic                     valid_s2;
	prod_beat_t               beat_s2;
	logic                     ready;
	logic signed [SAMPLE_BITS:0] sx;
	logic signed [SAMPLE_BITS:0] sy;
	logic signed [PROD_W-1:0] px_a;
	logic signed [PROD_W-1:0] px_b;
	logic signed [PROD_W-1:0] py_a;
	logic signed [PROD_W-1:0] py_b;

	assign ready    = !valid_s2 || dn_ready;
	assign up_ready = ready;

	// raw samples are unsigned
	assign sx = $signed({1'b0, pair_beat.rx});
	assign sy = $signed({1'b0, pair_beat.ry});

	assign px_a = coef.gain_xx * sx;
	assign px_b = coef.gain_xy * sy;
	assign py_a = coef.gain_yx * sx;
	assign py_b = coef.gain_yy * sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && pair_valid) begin
			beat_s2.touched <= pair_beat.touched;
			beat_s2.px_a    <= px_a;
			beat_s2.px_b    <= px_b;
			beat_s2.py_a    <= py_a;
			beat_s2.py_b    <= py_b;
		end
	end

	assign prod_valid = valid_s2;
	assign prod_beat  = beat_s2;

endmodule

/* src/tepac_sum.sv */
// ----------------------------------------------------------------------------
// tepac_sum
// Result stage: sums products and offset, truncates toward zero, saturates,
// keeps the last point and holds the output beat.
// ----------------------------------------------------------------------------
module tepac_sum
	import tepac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  coef_set_t  coef,
	input  logic       prod_valid,
	input  prod_beat_t prod_beat,
	output logic       up_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output out_beat_t  out_beat
);

	localparam logic signed [ACC_W-1:0] POS_HI = ACC_W'((1 << (POS_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] POS_LO = -ACC_W'(1 << (POS_W - 1));
	localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((1 << FRAC_BITS) - 1);

	function automatic logic signed [POS_W-1:0] to_pos(
		input logic signed [PROD_W-1:0] pa,
		input logic signed [PROD_W-1:0] pb,
		input logic signed [COEF_W-1:0] off
	);
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] q;
		acc = ACC_W'(pa) + ACC_W'(pb) + ACC_W'(off);
		// bias negative values so the shift rounds toward zero
		q   = (acc[ACC_W-1] ? acc + FRAC_MASK : acc) >>> FRAC_BITS;
		if (q > POS_HI) begin
			q = POS_HI;
		end else if (q < POS_LO) begin
			q = POS_LO;
		end
		return q[POS_W-1:0];
	endfunction

	logic                    valid_q;
	out_beat_t               beat_q;
	logic signed [POS_W-1:0] last_x_q;
	logic signed [POS_W-1:0] last_y_q;
	logic                    ready;
	logic                    load;
	logic signed [POS_W-1:0] new_x;
	logic signed [POS_W-1:0] new_y;

	assign ready    = !valid_q || !out_stall;
	assign up_ready = ready;
	assign load     = ready && prod_valid;

	assign new_x = to_pos(prod_beat.px_a, prod_beat.px_b, coef.offset_x);
	assign new_y = to_pos(prod_beat.py_a, prod_beat.py_b, coef.offset_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			if (ready) begin
				valid_q <= prod_valid;
			end
			if (load && prod_beat.touched) begin
				last_x_q <= new_x;
				last_y_q <= new_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q.touched <= prod_beat.touched;
			beat_q.pos_x   <= prod_beat.touched ? new_x : last_x_q;
			beat_q.pos_y   <= prod_beat.touched ? new_y : last_y_q;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

/* src/touch_event_pair_affine_calibration.sv */
// pipeline: three registers (pairing, products, sum and saturate) lie between
// an accepted input beat and its result beat; one input beat per cycle while
// out_stall is low, with bubbles squeezed out under output stall
// reset: pairing flags clear, last point and offsets go to zero, gains xx and
// yy to 1.0, gains xy and yx to zero; no clearing pass, the block takes beats
// right after reset
// ----------------------------------------------------------------------------
// touch_event_pair_affine_calibration
// Pairs raw X/Y axis events and maps each pair to screen coordinates with
// a six-coefficient fixed-point affine transform.
// ----------------------------------------------------------------------------
module touch_event_pair_affine_calibration
	import tepac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_beat,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [COEF_W-1:0]    cfg_wdata
);

	coef_set_t  coef;
	logic       pair_valid;
	pair_beat_t pair_beat;
	logic       mul_ready;
	logic       prod_valid;
	prod_beat_t prod_beat;
	logic       sum_ready;

	tepac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	tepac_pair u_pair (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.dn_ready   (mul_ready),
		.pair_valid (pair_valid),
		.pair_beat  (pair_beat)
	);

	tepac_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.pair_valid (pair_valid),
		.pair_beat  (pair_beat),
		.up_ready   (mul_ready),
		.dn_ready   (sum_ready),
		.prod_valid (prod_valid),
		.prod_beat  (prod_beat)
	);

	tepac_sum u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.prod_valid (prod_valid),
		.prod_beat  (prod_beat),
		.up_ready   (sum_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

endmodule

/* test/touch_event_pair_affine_calibration_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_event_pair_affine_calibration_tb
// Drives axis events and idle ticks through the pairing and calibration
// block under random input gaps and output stalls. The calibration set is
// rewritten between phases. A scoreboard predicts every calibrated point
// and compares each output beat field by field.
// ----------------------------------------------------------------------------
module touch_event_pair_affine_calibration_tb;
	import tepac_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int DRAIN_CYCLES   = 4;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 95;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	// tracks pairing state and holds the points the block still owes
	class point_ledger;
		out_beat_t               expected_points[$];
		coef_set_t               coefs;
		logic                    have_x, have_y;
		logic [SAMPLE_BITS-1:0]  raw_x, raw_y;
		logic signed [POS_W-1:0] last_x, last_y;
		int                      errors;

		function new();
			coefs.gain_xx  = 32'sd65536;
			coefs.gain_xy  = '0;
			coefs.offset_x = '0;
			coefs.gain_yx  = '0;
			coefs.gain_yy  = 32'sd65536;
			coefs.offset_y = '0;
			have_x = 1'b0;
			have_y = 1'b0;
			raw_x  = '0;
			raw_y  = '0;
			last_x = '0;
			last_y = '0;
			errors = 0;
		endfunction

		function void set_coef(reg_idx_t idx, logic [COEF_W-1:0] v);
			case (idx)
				REG_GAIN_XX:  coefs.gain_xx  = v;
				REG_GAIN_XY:  coefs.gain_xy  = v;
				REG_OFFSET_X: coefs.offset_x = v;
				REG_GAIN_YX:  coefs.gain_yx  = v;
				REG_GAIN_YY:  coefs.gain_yy  = v;
				REG_OFFSET_Y: coefs.offset_y = v;
				default: ;
			endcase
		endfunction

		static function logic signed [POS_W-1:0] map_axis(logic signed [COEF_W-1:0] ga,
				logic signed [COEF_W-1:0] gb, logic signed [COEF_W-1:0] off,
				logic [SAMPLE_BITS-1:0] rx, logic [SAMPLE_BITS-1:0] ry);
			longint acc, q;
			acc = longint'(ga) * longint'(rx) + longint'(gb) * longint'(ry) + longint'(off);
			// signed divide truncates toward zero
			q = acc / (longint'(1) << FRAC_BITS);
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return q[POS_W-1:0];
		endfunction

		function void note_beat(in_beat_t b);
			out_beat_t e;
			if (b.op == OP_IDLE) begin
				e.touched = 1'b0;
				e.pos_x   = last_x;
				e.pos_y   = last_y;
				expected_points.push_back(e);
				return;
			end
			if (b.ev_type == EV_ABS) begin
				if (b.ev_code == AXIS_X && !have_x) begin
					raw_x  = b.ev_value[SAMPLE_BITS-1:0];
					have_x = 1'b1;
				end else if (b.ev_code == AXIS_Y && !have_y) begin
					raw_y  = b.ev_value[SAMPLE_BITS-1:0];
					have_y = 1'b1;
				end
			end
			if (have_x && have_y) begin
				last_x = map_axis(coefs.gain_xx, coefs.gain_xy, coefs.offset_x, raw_x, raw_y);
				last_y = map_axis(coefs.gain_yx, coefs.gain_yy, coefs.offset_y, raw_x, raw_y);
				have_x = 1'b0;
				have_y = 1'b0;
				e.touched = 1'b1;
				e.pos_x   = last_x;
				e.pos_y   = last_y;
				expected_points.push_back(e);
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_point(out_beat_t got);
			out_beat_t e;
			if (expected_points.size() == 0) begin
				report($sformatf("unexpected beat touched=%0b x=%0d y=%0d",
					got.touched, got.pos_x, got.pos_y));
				return;
			end
			e = expected_points.pop_front();
			if (got.touched !== e.touched)
				report($sformatf("touched got %0b want %0b", got.touched, e.touched));
			if (got.pos_x !== e.pos_x)
				report($sformatf("pos_x got %0d want %0d", got.pos_x, e.pos_x));
			if (got.pos_y !== e.pos_y)
				report($sformatf("pos_y got %0d want %0d", got.pos_y, e.pos_y));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_beat_t             in_beat;
	logic                 out_valid;
	logic                 out_stall;
	out_beat_t            out_beat;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [COEF_W-1:0]    cfg_wdata;

	point_ledger sb;
	stall_mode_e stall_mode = STALL_NONE;
	bit          long_hold  = 1'b0;
	bit          gaps_on    = 1'b0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	reg_idx_t    reg_order [6] = '{REG_GAIN_XX, REG_GAIN_XY, REG_OFFSET_X,
		REG_GAIN_YX, REG_GAIN_YY, REG_OFFSET_Y};

	touch_event_pair_affine_calibration dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall)
				sb.note_beat(in_beat);
			if (out_valid && !out_stall)
				sb.check_point(out_beat);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver stall pattern, with an occasional long hold-off
	initial begin
		int tick;
		tick = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			tick++;
			case (stall_mode)
				STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 40);
				STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	function automatic in_beat_t mk_beat(logic op, logic [FIELD_W-1:0] ev_type,
			logic [FIELD_W-1:0] ev_code, logic [FIELD_W-1:0] ev_value);
		in_beat_t b;
		b.op       = op;
		b.ev_type  = ev_type;
		b.ev_code  = ev_code;
		b.ev_value = ev_value;
		return b;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return FIELD_W'($urandom);
			default: return FIELD_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// an event the block drops, or a lone axis sample
	function automatic in_beat_t rand_noise();
		logic [FIELD_W-1:0] t;
		case ($urandom_range(0, 2))
			0: begin
				t = FIELD_W'($urandom);
				if (t == EV_ABS)
					t = ~t;
				return mk_beat(OP_EVENT, t, FIELD_W'($urandom_range(0, 1) ? $urandom
					: $urandom_range(0, 1)), FIELD_W'($urandom));
			end
			1: return mk_beat(OP_EVENT, EV_ABS, FIELD_W'($urandom_range(2, 65535)),
				FIELD_W'($urandom));
			default: return mk_beat(OP_EVENT, EV_ABS,
				$urandom_range(0, 1) ? AXIS_Y : AXIS_X, rand_sample());
		endcase
	endfunction

	function automatic coef_set_t rand_coefs(bit wild);
		coef_set_t c;
		if (wild) begin
			c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			// gains within +-2.0, offsets within +-512 pixels
			c.gain_xx  = int'($urandom_range(0, 262144)) - 131072;
			c.gain_xy  = int'($urandom_range(0, 262144)) - 131072;
			c.gain_yx  = int'($urandom_range(0, 262144)) - 131072;
			c.gain_yy  = int'($urandom_range(0, 262144)) - 131072;
			c.offset_x = int'($urandom_range(0, 67108864)) - 33554432;
			c.offset_y = int'($urandom_range(0, 67108864)) - 33554432;
		end
		return c;
	endfunction

	task automatic send_item(input in_beat_t b);
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_beat  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// steps past the last accepted beat first so the monitor has noted it
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_coefs(input coef_set_t c);
		logic [COEF_W-1:0] vals [6];
		vals = '{c.gain_xx, c.gain_xy, c.offset_x, c.gain_yx, c.gain_yy, c.offset_y};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= reg_order[i];
			cfg_wdata <= vals[i];
			sb.set_coef(reg_order[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_traffic(input int n_items);
		int sent;
		int pick;
		bit y_first;
		logic [FIELD_W-1:0] vx, vy;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				vx = rand_sample();
				vy = rand_sample();
				y_first = $urandom_range(0, 1);
				send_item(mk_beat(OP_EVENT, EV_ABS, y_first ? AXIS_Y : AXIS_X,
					y_first ? vy : vx));
				// a repeated axis, stray event or idle tick inside the pair
				case ($urandom_range(0, 5))
					0: send_item(mk_beat(OP_EVENT, EV_ABS, y_first ? AXIS_Y : AXIS_X,
						rand_sample()));
					1: send_item(rand_noise());
					2: begin
						send_item(mk_beat(OP_IDLE, FIELD_W'($urandom), FIELD_W'($urandom),
							FIELD_W'($urandom)));
						sent++;
					end
					default: ;
				endcase
				send_item(mk_beat(OP_EVENT, EV_ABS, y_first ? AXIS_X : AXIS_Y,
					y_first ? vx : vy));
				sent += 2;
			end else if (pick < 80) begin
				send_item(mk_beat(OP_IDLE, FIELD_W'($urandom), FIELD_W'($urandom),
					FIELD_W'($urandom)));
				sent++;
			end else begin
				send_item(rand_noise());
			end
		end
	endtask

	initial begin
		coef_set_t c;
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_beat   <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_GAIN_XX;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset calibration (identity)
		send_item(mk_beat(OP_IDLE, '0, '0, '0));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, '0));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, '0));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, '1));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, '1));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, 16'd100));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, 16'd200));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, 16'd300));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, 16'd5));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, 16'd9));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, 16'd7));
		send_item(mk_beat(OP_EVENT, '0, AXIS_X, 16'd1));
		send_item(mk_beat(OP_EVENT, '1, AXIS_Y, 16'd2));
		send_item(mk_beat(OP_EVENT, EV_ABS, 16'd2, 16'd3));
		send_item(mk_beat(OP_EVENT, EV_ABS, '1, '1));
		send_item(mk_beat(OP_EVENT, EV_ABS - 16'd1, AXIS_X, 16'd4));
		send_item(mk_beat(OP_IDLE, '1, '1, '1));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, 16'd32767));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, 16'd32768));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_X, 16'd32768));
		send_item(mk_beat(OP_EVENT, EV_ABS, AXIS_Y, 16'd1));
		send_item(mk_beat(OP_IDLE, '0, '0, '0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: c = {6{32'h7fff_ffff}};
				1: c = {6{32'h8000_0000}};
				2: c = '0;
				3: begin
					// swapped axes, offsets of -99.5 to catch truncation direction
					c = '0;
					c.gain_xy  = 32'sd65536;
					c.gain_yx  = 32'sd65536;
					c.offset_x = -(32'sd100 <<< FRAC_BITS) + 32'sd32768;
					c.offset_y = -(32'sd100 <<< FRAC_BITS) + 32'sd32768;
				end
				default: c = rand_coefs(p[0]);
			endcase
			drain();
			load_coefs(c);
			if (p == 0) begin
				stall_mode = STALL_NONE;
				gaps_on    = 1'b0;
			end else begin
				stall_mode = stall_mode_e'($urandom_range(0, 2));
				gaps_on    = $urandom_range(0, 3) != 0;
			end
			if (p == 3) begin
				// back-to-back beats against a held-off receiver
				gaps_on   = 1'b0;
				long_hold = 1'b1;
				run_traffic(40);
				gaps_on   = 1'b1;
			end
			run_traffic(PHASE_ITEMS);
		end

		stall_mode = STALL_NONE;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* touch_event_pair_affine_calibration.f */
src/tepac_pkg.sv
src/tepac_cfg.sv
src/tepac_pair.sv
src/tepac_mul.sv
src/tepac_sum.sv
src/touch_event_pair_affine_calibration.sv
test/touch_event_pair_affine_calibration_tb.sv
